// ----- rtl/lgs_pkg.sv -----
// Shared types and constants for the life generation step core.
package lgs_pkg;

   localparam int GRID_ROWS_DEF = 64;
   localparam int GRID_COLS_DEF = 64;
   localparam int ROW_FIELD_W   = 6;
   localparam int COL_FIELD_W   = 6;
   localparam int BITS_W        = 64;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WR_MOD,
      ST_GEN_PRE1,
      ST_GEN_PRE2,
      ST_GEN_RUN
   } lgs_state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_GEN   = 1'b1;

endpackage

// ----- rtl/lgs_req_if.sv -----
// Request channel: one cell write or one generation step.
interface lgs_req_if
   import lgs_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic                   mode;
   logic [ROW_FIELD_W-1:0] row;
   logic [COL_FIELD_W-1:0] col;
   logic                   cell_value;

   modport source (output valid, mode, row, col, cell_value, input ready);
   modport sink   (input valid, mode, row, col, cell_value, output ready);
endinterface

// ----- rtl/lgs_rsp_if.sv -----
// Result channel: one grid row of a new generation.
interface lgs_rsp_if
   import lgs_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [ROW_FIELD_W-1:0] out_row;
   logic [BITS_W-1:0]      alive_bits;
   logic [BITS_W-1:0]      changed_bits;
   logic                   last_row;

   modport source (output valid, out_row, alive_bits, changed_bits, last_row, input ready);
   modport sink   (input valid, out_row, alive_bits, changed_bits, last_row, output ready);
endinterface

// ----- rtl/life_generation_step_core.sv -----
// Top level: toroidal B3/S23 grid with cell writes and whole-grid generation steps.
// Cell write: read the row, then write the modified row back; no result.
// Generation: prime the row window, then one row per cycle unless results stall;
// single memory read port, GRID_ROWS results in all; rows written back in place.
// Reset clears the per-row valid bits at once, so the grid reads as all dead.
module life_generation_step_core
   import lgs_pkg::*;
#(
   parameter int GRID_ROWS = GRID_ROWS_DEF,
   parameter int GRID_COLS = GRID_COLS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   lgs_req_if.sink   req_ch,
   lgs_rsp_if.source rsp_ch
);

   localparam int ROW_W = $clog2(GRID_ROWS);
   localparam int COL_W = $clog2(GRID_COLS);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GRID_ROWS - 1);
   localparam logic [ROW_W-1:0] PENULT_ROW = ROW_W'(GRID_ROWS - 2);
   localparam logic [ROW_FIELD_W:0] ROW_LIM = (ROW_FIELD_W + 1)'(GRID_ROWS);
   localparam logic [COL_FIELD_W:0] COL_LIM = (COL_FIELD_W + 1)'(GRID_COLS);

   lgs_state_type state_ff, state_in;

   logic [ROW_W-1:0]     cur_ff, cur_in;
   logic [GRID_COLS-1:0] up_ff, up_in;
   logic [GRID_COLS-1:0] mid_ff, mid_in;
   logic [GRID_COLS-1:0] first_ff, first_in;
   logic [ROW_W-1:0]     wrow_ff, wrow_in;
   logic [COL_W-1:0]     wcol_ff, wcol_in;
   logic                 wval_ff, wval_in;

   logic                   out_valid_ff, out_valid_in;
   logic [ROW_FIELD_W-1:0] out_row_ff, out_row_in;
   logic [BITS_W-1:0]      alive_ff, alive_in;
   logic [BITS_W-1:0]      changed_ff, changed_in;
   logic                   last_ff, last_in;

   mem_ctl_type          mem_ctl;
   logic [ROW_W-1:0]     rd_addr;
   logic [ROW_W-1:0]     wr_addr;
   logic [GRID_COLS-1:0] wr_data;
   logic [GRID_COLS-1:0] rd_data;
   logic [GRID_COLS-1:0] down_row;
   logic [GRID_COLS-1:0] alive_row;
   logic [GRID_COLS-1:0] mod_row;

   logic req_fire;
   logic adv;
   logic in_range;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign adv      = !out_valid_ff || rsp_ch.ready;
   assign in_range = ({1'b0, req_ch.row} < ROW_LIM) && ({1'b0, req_ch.col} < COL_LIM);
   assign down_row = (cur_ff == LAST_ROW) ? first_ff : rd_data;

   always_comb begin
      mod_row          = rd_data;
      mod_row[wcol_ff] = wval_ff;
   end

   lgs_grid_mem #(
      .GRID_ROWS (GRID_ROWS),
      .GRID_COLS (GRID_COLS)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mem_ctl),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   lgs_row_rule #(
      .GRID_COLS (GRID_COLS)
   ) u_rule (
      .up_row    (up_ff),
      .mid_row   (mid_ff),
      .down_row  (down_row),
      .alive_row (alive_row)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_ch.mode == MODE_GEN) begin
                  state_in = ST_GEN_PRE1;
               end else if (in_range) begin
                  state_in = ST_WR_MOD;
               end
            end
         end
         ST_WR_MOD:   state_in = ST_IDLE;
         ST_GEN_PRE1: state_in = ST_GEN_PRE2;
         ST_GEN_PRE2: state_in = ST_GEN_RUN;
         ST_GEN_RUN: begin
            if (adv && (cur_ff == LAST_ROW)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ch.ready  = 1'b0;
      mem_ctl       = '0;
      rd_addr       = '0;
      wr_addr       = cur_ff;
      wr_data       = alive_row;
      cur_in        = cur_ff;
      up_in         = up_ff;
      mid_in        = mid_ff;
      first_in      = first_ff;
      wrow_in       = wrow_ff;
      wcol_in       = wcol_ff;
      wval_in       = wval_ff;
      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      out_row_in    = out_row_ff;
      alive_in      = alive_ff;
      changed_in    = changed_ff;
      last_in       = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_fire) begin
               mem_ctl.rd_en = 1'b1;
               rd_addr = (req_ch.mode == MODE_GEN) ? LAST_ROW : req_ch.row[ROW_W-1:0];
               wrow_in = req_ch.row[ROW_W-1:0];
               wcol_in = req_ch.col[COL_W-1:0];
               wval_in = req_ch.cell_value;
            end
         end
         ST_WR_MOD: begin
            mem_ctl.wr_en = 1'b1;
            wr_addr = wrow_ff;
            wr_data = mod_row;
         end
         ST_GEN_PRE1: begin
            mem_ctl.rd_en = 1'b1;
            rd_addr = '0;
            up_in   = rd_data;
         end
         ST_GEN_PRE2: begin
            mem_ctl.rd_en = 1'b1;
            rd_addr  = ROW_W'(1);
            mid_in   = rd_data;
            first_in = rd_data;
            cur_in   = '0;
         end
         ST_GEN_RUN: begin
            if (adv) begin
               mem_ctl.wr_en = 1'b1;
               if (cur_ff < PENULT_ROW) begin
                  mem_ctl.rd_en = 1'b1;
                  rd_addr = ROW_W'(cur_ff + ROW_W'(2));
               end
               up_in        = mid_ff;
               mid_in       = down_row;
               cur_in       = ROW_W'(cur_ff + ROW_W'(1));
               out_valid_in = 1'b1;
               out_row_in   = ROW_FIELD_W'(cur_ff);
               alive_in     = BITS_W'(alive_row);
               changed_in   = BITS_W'(alive_row ^ mid_ff);
               last_in      = (cur_ff == LAST_ROW);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         cur_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         cur_ff       <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      up_ff      <= up_in;
      mid_ff     <= mid_in;
      first_ff   <= first_in;
      wrow_ff    <= wrow_in;
      wcol_ff    <= wcol_in;
      wval_ff    <= wval_in;
      out_row_ff <= out_row_in;
      alive_ff   <= alive_in;
      changed_ff <= changed_in;
      last_ff    <= last_in;
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.out_row      = out_row_ff;
   assign rsp_ch.alive_bits   = alive_ff;
   assign rsp_ch.changed_bits = changed_ff;
   assign rsp_ch.last_row     = last_ff;

   a_no_rw_same_row: assert property (@(posedge clock) disable iff (reset)
      (mem_ctl.rd_en && mem_ctl.wr_en) |-> (rd_addr != wr_addr))
      else $error("read and write of the same row in one cycle");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !mem_ctl.wr_en)
      else $error("grid written while taking requests");

   a_last_row_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.last_row) |-> (rsp_ch.out_row == ROW_FIELD_W'(GRID_ROWS - 1)))
      else $error("last row flag on wrong row");

   a_gen_start: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_ch.mode == MODE_GEN)) |=> (state_ff == ST_GEN_PRE1))
      else $error("generation request did not start the row window");

endmodule

// ----- rtl/lgs_grid_mem.sv -----
// Grid storage: one row per word, per-row valid bits, registered read.
module lgs_grid_mem
   import lgs_pkg::*;
#(
   parameter int GRID_ROWS = GRID_ROWS_DEF,
   parameter int GRID_COLS = GRID_COLS_DEF,
   localparam int ROW_W = $clog2(GRID_ROWS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mem_ctl_type          ctl,
   input  logic [ROW_W-1:0]     rd_addr,
   input  logic [ROW_W-1:0]     wr_addr,
   input  logic [GRID_COLS-1:0] wr_data,
   output logic [GRID_COLS-1:0] rd_data
);

   logic [GRID_COLS-1:0] grid_ff [GRID_ROWS];
   logic [GRID_ROWS-1:0] valid_ff;
   logic [GRID_COLS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         grid_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl.wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // unwritten rows read as dead
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? grid_ff[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/lgs_row_rule.sv -----
// B3/S23 rule applied across one row, columns wrapping at the edges.
module lgs_row_rule
   import lgs_pkg::*;
#(
   parameter int GRID_COLS = GRID_COLS_DEF
) (
   input  logic [GRID_COLS-1:0] up_row,
   input  logic [GRID_COLS-1:0] mid_row,
   input  logic [GRID_COLS-1:0] down_row,
   output logic [GRID_COLS-1:0] alive_row
);

   function automatic logic next_cell(input logic [7:0] nb, input logic self);
      logic [3:0] n;
      n = '0;
      for (int i = 0; i < 8; i++) begin
         n = n + {3'b000, nb[i]};
      end
      return (n == 4'd3) || (self && (n == 4'd2));
   endfunction

   for (genvar c = 0; c < GRID_COLS; c++) begin : g_col
      localparam int CL = (c == 0) ? GRID_COLS - 1 : c - 1;
      localparam int CR = (c == GRID_COLS - 1) ? 0 : c + 1;
      assign alive_row[c] = next_cell({up_row[CL], up_row[c], up_row[CR],
                                       mid_row[CL], mid_row[CR],
                                       down_row[CL], down_row[c], down_row[CR]},
                                      mid_row[c]);
   end

endmodule

// ----- test/life_generation_step_core_checker.sv -----
// Watches both channels, tracks the expected grid and checks every generated row.
module life_generation_step_core_checker
   import lgs_pkg::*;
#(
   parameter int GRID_ROWS = GRID_ROWS_DEF,
   parameter int GRID_COLS = GRID_COLS_DEF
) (
   input  logic clock,
   input  logic reset,
   lgs_req_if   req_ch,
   lgs_rsp_if   rsp_ch,
   output int   fail_count,
   output int   rows_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [ROW_FIELD_W-1:0] out_row;
      logic [BITS_W-1:0]      alive_bits;
      logic [BITS_W-1:0]      changed_bits;
      logic                   last_row;
   } row_result_type;

   logic [BITS_W-1:0] cell_grid [GRID_ROWS];
   row_result_type    row_results_q [$];

   initial begin
      fail_count   = 0;
      rows_pending = 0;
   end

   task automatic report_mismatch(input string what);
      $display("%0t ns  mismatch: %s", $time, what);
      fail_count++;
   endtask

   function automatic int live_at(input int r, input int c);
      return int'(cell_grid[r][c]);
   endfunction

   // one whole generation: every row is queued, then the grid is replaced
   function automatic void advance_generation();
      logic [BITS_W-1:0] next_rows [GRID_ROWS];
      int                ru, rd, cl, cr, n;
      row_result_type    res;
      for (int r = 0; r < GRID_ROWS; r++) begin
         ru = (r + GRID_ROWS - 1) % GRID_ROWS;
         rd = (r + 1) % GRID_ROWS;
         next_rows[r] = '0;
         for (int c = 0; c < GRID_COLS; c++) begin
            cl = (c + GRID_COLS - 1) % GRID_COLS;
            cr = (c + 1) % GRID_COLS;
            n = live_at(ru, cl) + live_at(ru, c) + live_at(ru, cr)
              + live_at(r, cl) + live_at(r, cr)
              + live_at(rd, cl) + live_at(rd, c) + live_at(rd, cr);
            if (cell_grid[r][c])
               next_rows[r][c] = (n == 2) || (n == 3);
            else
               next_rows[r][c] = (n == 3);
         end
      end
      for (int r = 0; r < GRID_ROWS; r++) begin
         res.out_row      = ROW_FIELD_W'(r);
         res.alive_bits   = next_rows[r];
         res.changed_bits = next_rows[r] ^ cell_grid[r];
         res.last_row     = (r == GRID_ROWS - 1);
         row_results_q.push_back(res);
      end
      for (int r = 0; r < GRID_ROWS; r++)
         cell_grid[r] = next_rows[r];
   endfunction

   // sampled mid-cycle: a handshake seen here completes at the next rising edge
   always @(negedge clock) begin
      row_result_type want;
      if (reset) begin
         for (int r = 0; r < GRID_ROWS; r++)
            cell_grid[r] = '0;
         row_results_q.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (row_results_q.size() == 0) begin
               report_mismatch($sformatf("row %0d given with no generation request pending",
                                         rsp_ch.out_row));
            end else begin
               want = row_results_q.pop_front();
               if (rsp_ch.out_row !== want.out_row)
                  report_mismatch($sformatf("out_row %0d, expected %0d",
                                            rsp_ch.out_row, want.out_row));
               if (rsp_ch.alive_bits !== want.alive_bits)
                  report_mismatch($sformatf("row %0d alive_bits %h, expected %h", want.out_row,
                                            rsp_ch.alive_bits, want.alive_bits));
               if (rsp_ch.changed_bits !== want.changed_bits)
                  report_mismatch($sformatf("row %0d changed_bits %h, expected %h",
                                            want.out_row, rsp_ch.changed_bits,
                                            want.changed_bits));
               if (rsp_ch.last_row !== want.last_row)
                  report_mismatch($sformatf("row %0d last_row %b, expected %b", want.out_row,
                                            rsp_ch.last_row, want.last_row));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.mode == MODE_GEN)
               advance_generation();
            else if (int'(req_ch.row) < GRID_ROWS && int'(req_ch.col) < GRID_COLS)
               cell_grid[req_ch.row][req_ch.col] = req_ch.cell_value;
         end
      end
      rows_pending = row_results_q.size();
   end

endmodule

// ----- test/life_generation_step_core_test.sv -----
// Top of the testbench: clock, reset, request and result stimulus, and the verdict.
module life_generation_step_core_test;
   import lgs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LONG_HOLD   = 300;
   localparam int PHASE_ITEMS = 45;
   localparam int TAIL_CYCLES = 20;

   logic clock = 1'b0;
   logic reset;
   logic hold_go = 1'b0;
   int   hold_count = 0;
   int   idle_pct = 0;
   int   stall_pct = 0;
   int   items_sent = 0;
   int   fail_count;
   int   rows_pending;

   lgs_req_if req_ch ();
   lgs_rsp_if rsp_ch ();

   life_generation_step_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   life_generation_step_core_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .fail_count   (fail_count),
      .rows_pending (rows_pending)
   );

   always #6 clock = ~clock;

   initial begin
      #10ms;
      $display("tb: failure");
      $finish;
   end

   // result side: random stalls, plus one long hold-off so the core backs up
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go && hold_count < LONG_HOLD) begin
            hold_count++;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   task automatic send_req(input logic mode, input logic [ROW_FIELD_W-1:0] row,
                           input logic [COL_FIELD_W-1:0] col, input logic value);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.mode       <= mode;
      req_ch.row        <= row;
      req_ch.col        <= col;
      req_ch.cell_value <= value;
      @(negedge clock);
      while (!req_ch.ready)
         @(negedge clock);
      @(posedge clock);
      items_sent++;
   endtask

   task automatic write_cell(input int row, input int col, input logic value);
      send_req(MODE_WRITE, ROW_FIELD_W'(row), COL_FIELD_W'(col), value);
   endtask

   task automatic step_generation();
      send_req(MODE_GEN, ROW_FIELD_W'($urandom), COL_FIELD_W'($urandom), 1'($urandom));
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (rows_pending != 0)
         @(posedge clock);
   endtask

   // mostly small patches with random content followed by steps; the rest is noise
   task automatic run_phase(input int n_items);
      logic [ROW_FIELD_W-1:0] r0;
      logic [COL_FIELD_W-1:0] c0;
      int                     goal, kind, h, w, density;
      goal = items_sent + n_items;
      while (items_sent < goal) begin
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            r0      = ROW_FIELD_W'($urandom);
            c0      = COL_FIELD_W'($urandom);
            h       = $urandom_range(2, 4);
            w       = $urandom_range(2, 4);
            density = $urandom_range(25, 65);
            for (int i = 0; i < h; i++)
               for (int j = 0; j < w; j++)
                  write_cell(r0 + i, c0 + j, $urandom_range(0, 99) < density);
            repeat ($urandom_range(1, 3))
               step_generation();
         end else if (kind < 85) begin
            send_req(MODE_WRITE, ROW_FIELD_W'($urandom), COL_FIELD_W'($urandom),
                     1'($urandom));
         end else if (kind < 93) begin
            step_generation();
         end else begin
            // patch left without a step
            r0 = ROW_FIELD_W'($urandom);
            c0 = COL_FIELD_W'($urandom);
            repeat ($urandom_range(1, 3)) begin
               write_cell(r0, c0, 1'($urandom));
               c0++;
            end
         end
      end
   endtask

   initial begin
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.mode       <= MODE_WRITE;
      req_ch.row        <= '0;
      req_ch.col        <= '0;
      req_ch.cell_value <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty grid stays empty
      step_generation();
      // vertical blinker wrapping bottom to top on the last column
      write_cell(63, 63, 1'b1);
      write_cell(0, 63, 1'b1);
      write_cell(1, 63, 1'b1);
      // horizontal blinker wrapping right to left
      write_cell(20, 63, 1'b1);
      write_cell(20, 0, 1'b1);
      write_cell(20, 1, 1'b1);
      // set then clear
      write_cell(40, 40, 1'b1);
      write_cell(40, 40, 1'b0);
      step_generation();
      step_generation();
      // glider across the corner
      write_cell(62, 1, 1'b1);
      write_cell(63, 2, 1'b1);
      write_cell(0, 0, 1'b1);
      write_cell(0, 1, 1'b1);
      write_cell(0, 2, 1'b1);
      repeat (3) step_generation();
      drain_results();

      hold_go <= 1'b1;
      run_phase(PHASE_ITEMS);
      drain_results();

      idle_pct <= 51;
      run_phase(PHASE_ITEMS);
      drain_results();

      idle_pct  <= 0;
      stall_pct <= 51;
      run_phase(PHASE_ITEMS);
      drain_results();

      idle_pct  <= 37;
      stall_pct <= 37;
      run_phase(PHASE_ITEMS);
      drain_results();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
